// File: rtl/ppdr_pkg.sv
// Shared types and constants for the point-to-polygon distance ring unit.
// Used by the channel interfaces, the shared multiply/divide unit and the top level.
// No dependencies.
package ppdr_pkg;

	localparam int MAX_W     = 44;   // largest squared vertex distance, integer
	localparam int MIN_W     = 60;   // smallest squared distance, with fraction bits
	localparam int RING_W    = 62;   // pi * (max - min), with fraction bits
	localparam int ACC_W     = 128;  // accumulator of the shared unit
	localparam int MPW       = 60;   // multiplier operand register
	localparam int QUO_BITS  = 60;   // quotient bits produced by a division
	localparam int CNT_W     = $clog2(QUO_BITS);
	localparam int ROUND_BIT = 59;   // half an LSB of pi * diff at Q60
	localparam int CFG_IDX_W = 1;

	// pi * 2^60, truncated
	localparam logic [RING_W-1:0] PI_Q60 = 62'h3243F6A8885A308D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 1'b0,
		REG_CENTER_Y = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic    negate;  // subtract the product instead of adding it
		logic    load;    // start from acc_init instead of the held accumulator
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;       // one-cycle pulse; the accumulator is final
	} alu_stat_t;

endpackage

// File: rtl/ppdr_ifs.sv
// Valid/ready channel interfaces of the point-to-polygon distance ring unit:
// vertex input, result output and configuration write channel.
// Depends on ppdr_pkg.
interface ppdr_vertex_if #(parameter int COORD_BITS = 21) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         last_vertex;

	modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface ppdr_result_if ();
	logic                             valid;
	logic                             ready;
	logic [ppdr_pkg::MAX_W-1:0]       max_dist_sq;
	logic [ppdr_pkg::MIN_W-1:0]       min_dist_sq_fixed;
	logic [ppdr_pkg::RING_W-1:0]      ring_area_fixed;

	modport source (output valid, max_dist_sq, min_dist_sq_fixed, ring_area_fixed,
		input ready);
	modport sink (input valid, max_dist_sq, min_dist_sq_fixed, ring_area_fixed,
		output ready);
endinterface

interface ppdr_cfg_if #(parameter int COORD_BITS = 21) ();
	logic                           valid;
	logic                           ready;
	logic [ppdr_pkg::CFG_IDX_W-1:0] index;
	logic signed [COORD_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/ppdr_mac_div.sv
// Shared iterative arithmetic unit: shift-add multiply-accumulate and restoring
// division, both on one wide adder. Depends on ppdr_pkg.
module ppdr_mac_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ppdr_pkg::alu_cmd_t             cmd,
	input  logic [ppdr_pkg::ACC_W-1:0]     mcand,
	input  logic [ppdr_pkg::MPW-1:0]       mplier,
	input  logic [ppdr_pkg::ACC_W-1:0]     acc_init,
	output ppdr_pkg::alu_stat_t            stat,
	output logic [ppdr_pkg::ACC_W-1:0]     acc
);

	localparam int AW = ppdr_pkg::ACC_W;

	logic                      busy_q;
	logic                      done_q;
	ppdr_pkg::alu_op_t         op_q;
	logic                      neg_q;
	logic [AW-1:0]             acc_q;
	logic [AW-1:0]             mcand_q;
	logic [ppdr_pkg::MPW-1:0]  mplier_q;
	logic [ppdr_pkg::CNT_W-1:0] cnt_q;

	logic [AW-1:0] add_a;
	logic [AW-1:0] add_b;
	logic          sub;
	logic [AW-1:0] sum;

	// Multiply adds or, when negated, subtracts the multiplicand; division shifts the
	// partial remainder left and trial-subtracts the divisor placed above the quotient bits.
	always_comb begin
		sub   = (op_q == ppdr_pkg::OP_DIV) || neg_q;
		add_a = (op_q == ppdr_pkg::OP_DIV) ? {acc_q[AW-2:0], 1'b0} : acc_q;
		add_b = sub ? ~mcand_q : mcand_q;
		sum   = add_a + add_b + AW'(sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ppdr_pkg::OP_MUL;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				neg_q  <= cmd.negate;
			end else if (busy_q) begin
				case (op_q)
					ppdr_pkg::OP_MUL: begin
						if (mplier_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					ppdr_pkg::OP_DIV: begin
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			cnt_q    <= ppdr_pkg::CNT_W'(ppdr_pkg::QUO_BITS - 1);
			if (cmd.load) begin
				acc_q <= acc_init;
			end
		end else if (busy_q) begin
			case (op_q)
				ppdr_pkg::OP_MUL: begin
					if (mplier_q != '0) begin
						if (mplier_q[0]) begin
							acc_q <= sum;
						end
						mcand_q  <= {mcand_q[AW-2:0], 1'b0};
						mplier_q <= mplier_q >> 1;
					end
				end
				ppdr_pkg::OP_DIV: begin
					// keep the shifted remainder when the trial goes negative
					acc_q <= sum[AW-1] ? add_a : (sum | AW'(1));
					cnt_q <= cnt_q - ppdr_pkg::CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign acc       = acc_q;

endmodule

// File: rtl/point_polygon_distance_ring_unit.sv
// Point-to-polygon distance ring unit: sequencer, polygon state and result register
// around the shared multiply/divide unit. Depends on ppdr_pkg, ppdr_ifs, ppdr_mac_div.
//
// Usage: write center_x (index 0) and center_y (index 1) on cfg while idle. Then
// stream polygon vertices on the vertex channel; last_vertex marks the final one.
// After the final vertex one transaction on result carries the largest squared
// vertex distance, the smallest squared distance to the boundary (16 fraction bits
// by default) and pi times their difference, and the polygon state clears.
// Throughput: one vertex at a time; vertex.ready is high only while idle. Every
// product runs on one shift-add unit, one multiplier bit per step up to its top
// set bit, and the division produces 60 quotient bits on the same unit.
// The last vertex also closes the polygon with an edge back to the first vertex
// and runs the 60-bit area multiply.
// The result sits in an output register; if the receiver stalls, the next polygon
// still streams in and only its final step waits for the register to drain.
// Reset clears the center, the polygon state and the output valid.
module point_polygon_distance_ring_unit #(
	parameter int COORD_BITS = 21,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ppdr_cfg_if.sink              cfg,
	ppdr_vertex_if.sink           vertex,
	ppdr_result_if.source         result
);

	localparam int CW    = COORD_BITS;
	localparam int RW    = CW + 1;       // coordinate relative to the center
	localparam int EW    = CW + 2;       // edge vector component
	localparam int LEN_W = 2 * CW + 3;   // squared edge length
	localparam int CRS_W = 2 * CW + 3;   // signed cross product
	localparam int AW    = ppdr_pkg::ACC_W;
	localparam int MNW   = ppdr_pkg::MIN_W;
	localparam int MXW   = ppdr_pkg::MAX_W;

	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_V_SQX  = 19'h00002,
		S_V_SQY  = 19'h00004,
		S_V_UPD  = 19'h00008,
		S_E_LX   = 19'h00010,
		S_E_LY   = 19'h00020,
		S_E_LCHK = 19'h00040,
		S_E_DX   = 19'h00080,
		S_E_DY   = 19'h00100,
		S_E_DCHK = 19'h00200,
		S_E_CX   = 19'h00400,
		S_E_CY   = 19'h00800,
		S_E_SQ   = 19'h01000,
		S_E_OVF  = 19'h02000,
		S_E_QUO  = 19'h04000,
		S_E_END  = 19'h08000,
		S_R_MUL  = 19'h10000,
		S_R_OUT  = 19'h20000,
		S_WAIT   = 19'h40000
	} state_t;

	state_t state_q;
	state_t ret_q;

	logic [CW-1:0]    center_x_q;
	logic [CW-1:0]    center_y_q;
	logic [RW-1:0]    cur_x_q;
	logic [RW-1:0]    cur_y_q;
	logic [RW-1:0]    first_x_q;
	logic [RW-1:0]    first_y_q;
	logic [RW-1:0]    prev_x_q;
	logic [RW-1:0]    prev_y_q;
	logic [RW-1:0]    a_x_q;
	logic [RW-1:0]    a_y_q;
	logic [EW-1:0]    e_x_q;
	logic [EW-1:0]    e_y_q;
	logic [LEN_W-1:0] len2_q;
	logic             last_q;
	logic             closing_q;
	logic             have_vertex_q;
	logic [MXW-1:0]   run_max_q;
	logic [MNW-1:0]   run_min_q;

	logic                          res_valid_q;
	logic [MXW-1:0]                res_max_q;
	logic [MNW-1:0]                res_min_q;
	logic [ppdr_pkg::RING_W-1:0]   res_ring_q;

	ppdr_pkg::alu_cmd_t   alu_cmd;
	ppdr_pkg::alu_stat_t  alu_stat;
	logic [AW-1:0]        alu_mcand;
	logic [ppdr_pkg::MPW-1:0] alu_mplier;
	logic [AW-1:0]        alu_init;
	logic [AW-1:0]        acc;

	logic [EW-1:0]    ma;
	logic [EW-1:0]    mb;
	logic             mneg;
	logic [EW-1:0]    mag_a;
	logic [EW-1:0]    mag_b;
	logic [CRS_W-1:0] crs;
	logic [CRS_W-1:0] crs_mag;
	logic [AW-1:0]    acc_sh;
	logic [MXW-1:0]   v_max_cand;
	logic [MNW-1:0]   v_min_cand;
	logic [AW-1:0]    max_wide;
	logic [AW-1:0]    max_sh;
	logic [MNW-1:0]   maxf;
	logic [MNW-1:0]   diff;
	logic             quo_ovf;
	logic             dot_off;
	logic             out_free;

	ppdr_mac_div u_mac_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (alu_cmd),
		.mcand    (alu_mcand),
		.mplier   (alu_mplier),
		.acc_init (alu_init),
		.stat     (alu_stat),
		.acc      (acc)
	);

	// Candidates and checks taken from the accumulator
	always_comb begin
		acc_sh     = acc << FRAC_BITS;
		v_max_cand = ((acc >> MXW) != '0) ? '1 : acc[MXW-1:0];
		v_min_cand = ((acc >> (MNW - FRAC_BITS)) != '0) ? '1 : acc_sh[MNW-1:0];
		max_wide   = AW'(run_max_q);
		max_sh     = max_wide << FRAC_BITS;
		maxf       = ((max_wide >> (MNW - FRAC_BITS)) != '0) ? '1 : max_sh[MNW-1:0];
		diff       = (maxf > run_min_q) ? (maxf - run_min_q) : '0;
		crs        = acc[CRS_W-1:0];
		crs_mag    = crs[CRS_W-1] ? CRS_W'(~crs + CRS_W'(1)) : crs;
		quo_ovf    = (acc >> ppdr_pkg::QUO_BITS) >= AW'(len2_q);
		dot_off    = acc[AW-1] || (acc > AW'(len2_q));
		out_free   = !res_valid_q || result.ready;
	end

	// Operand selection for the shared unit
	always_comb begin
		ma      = '0;
		mb      = '0;
		mneg    = 1'b0;
		alu_cmd = '{start: 1'b0, op: ppdr_pkg::OP_MUL, negate: 1'b0, load: 1'b0};
		case (state_q)
			S_V_SQX: begin
				ma = {cur_x_q[RW-1], cur_x_q};
				mb = {cur_x_q[RW-1], cur_x_q};
				alu_cmd.start = 1'b1;
				alu_cmd.load  = 1'b1;
			end
			S_V_SQY: begin
				ma = {cur_y_q[RW-1], cur_y_q};
				mb = {cur_y_q[RW-1], cur_y_q};
				alu_cmd.start = 1'b1;
			end
			S_E_LX: begin
				ma = e_x_q;
				mb = e_x_q;
				alu_cmd.start = 1'b1;
				alu_cmd.load  = 1'b1;
			end
			S_E_LY: begin
				ma = e_y_q;
				mb = e_y_q;
				alu_cmd.start = 1'b1;
			end
			S_E_DX: begin
				ma   = {a_x_q[RW-1], a_x_q};
				mb   = e_x_q;
				mneg = 1'b1;
				alu_cmd.start = 1'b1;
				alu_cmd.load  = 1'b1;
			end
			S_E_DY: begin
				ma   = {a_y_q[RW-1], a_y_q};
				mb   = e_y_q;
				mneg = 1'b1;
				alu_cmd.start = 1'b1;
			end
			S_E_CX: begin
				ma = {a_x_q[RW-1], a_x_q};
				mb = e_y_q;
				alu_cmd.start = 1'b1;
				alu_cmd.load  = 1'b1;
			end
			S_E_CY: begin
				ma   = {a_y_q[RW-1], a_y_q};
				mb   = e_x_q;
				mneg = 1'b1;
				alu_cmd.start = 1'b1;
			end
			S_E_SQ: begin
				alu_cmd.start = 1'b1;
				alu_cmd.load  = 1'b1;
			end
			S_E_OVF: begin
				alu_cmd.start = !quo_ovf;
				alu_cmd.op    = ppdr_pkg::OP_DIV;
			end
			S_R_MUL: begin
				alu_cmd.start = 1'b1;
				alu_cmd.load  = 1'b1;
			end
			default: ;
		endcase

		mag_a = ma[EW-1] ? EW'(~ma + EW'(1)) : ma;
		mag_b = mb[EW-1] ? EW'(~mb + EW'(1)) : mb;
		alu_cmd.negate = ma[EW-1] ^ mb[EW-1] ^ mneg;
		alu_mcand  = AW'(mag_a);
		alu_mplier = ppdr_pkg::MPW'(mag_b);
		alu_init   = '0;

		case (state_q)
			S_E_SQ: begin
				// dividend is cross^2 with the fraction bits below it
				alu_mcand      = AW'(crs_mag) << FRAC_BITS;
				alu_mplier     = ppdr_pkg::MPW'(crs_mag);
				alu_cmd.negate = 1'b0;
			end
			S_E_OVF: begin
				alu_mcand      = AW'(len2_q) << ppdr_pkg::QUO_BITS;
				alu_cmd.negate = 1'b0;
			end
			S_R_MUL: begin
				alu_mcand      = AW'(ppdr_pkg::PI_Q60);
				alu_mplier     = ppdr_pkg::MPW'(diff);
				alu_init       = AW'(1) << ppdr_pkg::ROUND_BIT;
				alu_cmd.negate = 1'b0;
			end
			default: ;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				ppdr_pkg::REG_CENTER_X: center_x_q <= cfg.data;
				ppdr_pkg::REG_CENTER_Y: center_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer and polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			first_x_q     <= '0;
			first_y_q     <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			a_x_q         <= '0;
			a_y_q         <= '0;
			e_x_q         <= '0;
			e_y_q         <= '0;
			len2_q        <= '0;
			last_q        <= 1'b0;
			closing_q     <= 1'b0;
			have_vertex_q <= 1'b0;
			run_max_q     <= '0;
			run_min_q     <= '1;
			res_valid_q   <= 1'b0;
		end else begin
			if (result.ready && !(state_q == S_R_OUT && out_free)) begin
				res_valid_q <= 1'b0;
			end
			if (alu_cmd.start) begin
				state_q <= S_WAIT;
			end
			case (state_q)
				S_IDLE: begin
					if (vertex.valid) begin
						cur_x_q <= {vertex.vertex_x[CW-1], vertex.vertex_x}
							- {center_x_q[CW-1], center_x_q};
						cur_y_q <= {vertex.vertex_y[CW-1], vertex.vertex_y}
							- {center_y_q[CW-1], center_y_q};
						last_q  <= vertex.last_vertex;
						state_q <= S_V_SQX;
					end
				end
				S_V_SQX:  ret_q <= S_V_SQY;
				S_V_SQY:  ret_q <= S_V_UPD;
				S_V_UPD: begin
					if (v_max_cand > run_max_q) begin
						run_max_q <= v_max_cand;
					end
					if (v_min_cand < run_min_q) begin
						run_min_q <= v_min_cand;
					end
					prev_x_q  <= cur_x_q;
					prev_y_q  <= cur_y_q;
					closing_q <= 1'b0;
					if (have_vertex_q) begin
						a_x_q   <= prev_x_q;
						a_y_q   <= prev_y_q;
						e_x_q   <= {cur_x_q[RW-1], cur_x_q} - {prev_x_q[RW-1], prev_x_q};
						e_y_q   <= {cur_y_q[RW-1], cur_y_q} - {prev_y_q[RW-1], prev_y_q};
						state_q <= S_E_LX;
					end else begin
						first_x_q     <= cur_x_q;
						first_y_q     <= cur_y_q;
						have_vertex_q <= 1'b1;
						state_q       <= S_E_END;
					end
				end
				S_E_LX:   ret_q <= S_E_LY;
				S_E_LY:   ret_q <= S_E_LCHK;
				S_E_LCHK: begin
					len2_q  <= acc[LEN_W-1:0];
					// drop zero-length edges
					state_q <= (acc == '0) ? S_E_END : S_E_DX;
				end
				S_E_DX:   ret_q <= S_E_DY;
				S_E_DY:   ret_q <= S_E_DCHK;
				S_E_DCHK: state_q <= dot_off ? S_E_END : S_E_CX;
				S_E_CX:   ret_q <= S_E_CY;
				S_E_CY:   ret_q <= S_E_SQ;
				S_E_SQ:   ret_q <= S_E_OVF;
				S_E_OVF: begin
					// a quotient that overflows is skipped, since it could never lower the minimum
					if (quo_ovf) begin
						state_q <= S_E_END;
					end
					ret_q <= S_E_QUO;
				end
				S_E_QUO: begin
					if (acc[MNW-1:0] < run_min_q) begin
						run_min_q <= acc[MNW-1:0];
					end
					state_q <= S_E_END;
				end
				S_E_END: begin
					if (closing_q) begin
						state_q <= S_R_MUL;
					end else if (last_q) begin
						a_x_q     <= cur_x_q;
						a_y_q     <= cur_y_q;
						e_x_q     <= {first_x_q[RW-1], first_x_q} - {cur_x_q[RW-1], cur_x_q};
						e_y_q     <= {first_y_q[RW-1], first_y_q} - {cur_y_q[RW-1], cur_y_q};
						closing_q <= 1'b1;
						state_q   <= S_E_LX;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_R_MUL:  ret_q <= S_R_OUT;
				S_R_OUT: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						first_x_q     <= '0;
						first_y_q     <= '0;
						prev_x_q      <= '0;
						prev_y_q      <= '0;
						have_vertex_q <= 1'b0;
						closing_q     <= 1'b0;
						run_max_q     <= '0;
						run_min_q     <= '1;
						state_q       <= S_IDLE;
					end
				end
				S_WAIT: begin
					if (alu_stat.done) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == S_R_OUT && out_free) begin
			res_max_q  <= run_max_q;
			res_min_q  <= run_min_q;
			res_ring_q <= acc[ppdr_pkg::QUO_BITS +: ppdr_pkg::RING_W];
		end
	end

	assign cfg.ready                = 1'b1;
	assign vertex.ready             = (state_q == S_IDLE);
	assign result.valid             = res_valid_q;
	assign result.max_dist_sq       = res_max_q;
	assign result.min_dist_sq_fixed = res_min_q;
	assign result.ring_area_fixed   = res_ring_q;

	a_ready_alu_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.ready |-> !alu_stat.busy)
		else $error("vertex accepted while the shared unit is busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_stat.done |-> (state_q == S_WAIT))
		else $error("shared unit finished while the sequencer was not waiting");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_R_OUT && out_free) |=>
			(res_valid_q && run_max_q == '0 && !have_vertex_q))
		else $error("result emitted without clearing the polygon state");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !have_vertex_q) |-> (run_max_q == '0 && run_min_q == '1))
		else $error("running extremes not cleared between polygons");

endmodule
